@@ rtl/dth_pkg.sv @@
// shared types, constants and codes for the deadline timer heap
package dth_pkg;

  localparam int CAPACITY_DEF  = 32;
  localparam int TIME_BITS_DEF = 48;
  localparam int MAX_FIRED     = 32;

  localparam logic [1:0] KIND_SCHED  = 2'd0;
  localparam logic [1:0] KIND_CANCEL = 2'd1;
  localparam logic [1:0] KIND_TICK   = 2'd2;
  localparam logic [1:0] KIND_NONE   = 2'd3;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_NOT_PEND = 2'd2;

  typedef struct packed {
    logic [1:0]  kind;
    logic [47:0] timestamp;
    logic [4:0]  task_handle;
  } dth_in_t;

  typedef struct packed {
    logic [4:0]  out_handle;
    logic        fired;
    logic [1:0]  status;
    logic [47:0] next_deadline;
    logic [5:0]  task_count;
    logic        last;
  } dth_out_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCHED,
    S_UP_RD,
    S_UP_CMP,
    S_HEAD_RD,
    S_HEAD_CHK,
    S_POP_MOVE,
    S_POP_LD,
    S_DN_RD,
    S_DN_CMP,
    S_EMIT
  } dth_state_t;

endpackage

@@ rtl/dth_heap_mem.sv @@
// heap entry storage: one write port, two registered read ports
module dth_heap_mem #(
  parameter int CAPACITY  = dth_pkg::CAPACITY_DEF,
  parameter int TIME_BITS = dth_pkg::TIME_BITS_DEF,
  parameter int AW        = $clog2(CAPACITY)
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [AW-1:0]        waddr,
  input  logic [TIME_BITS-1:0] wdl,
  input  logic [5:0]           whd,
  input  logic [AW-1:0]        raddr_a,
  input  logic [AW-1:0]        raddr_b,
  output logic [TIME_BITS-1:0] rdl_a,
  output logic [5:0]           rhd_a,
  output logic [TIME_BITS-1:0] rdl_b,
  output logic [5:0]           rhd_b
);
  import dth_pkg::*;

  logic [TIME_BITS+5:0] mem [CAPACITY];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= {wdl, whd};
    end
    {rdl_a, rhd_a} <= mem[raddr_a];
    {rdl_b, rhd_b} <= mem[raddr_b];
  end

endmodule

@@ rtl/dth_ctrl.sv @@
// sequencer: slot allocation, sift up/down, tick pops and summary results
module dth_ctrl #(
  parameter int CAPACITY  = dth_pkg::CAPACITY_DEF,
  parameter int TIME_BITS = dth_pkg::TIME_BITS_DEF,
  parameter int AW        = $clog2(CAPACITY)
) (
  input  logic                  clk,
  input  logic                  rst,
  input  dth_pkg::dth_in_t      in_req,
  input  logic                  in_valid,
  output logic                  in_stall,
  output dth_pkg::dth_out_t     out_req,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  we,
  output logic [AW-1:0]         waddr,
  output logic [TIME_BITS-1:0]  wdl,
  output logic [5:0]            whd,
  output logic [AW-1:0]         raddr_a,
  output logic [AW-1:0]         raddr_b,
  input  logic [TIME_BITS-1:0]  rdl_a,
  input  logic [5:0]            rhd_a,
  input  logic [TIME_BITS-1:0]  rdl_b,
  input  logic [5:0]            rhd_b
);
  import dth_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int IW = AW + 2;

  dth_state_t state, state_next;

  logic [CAPACITY-1:0]  pending, cancelled;
  logic [CW-1:0]        size;
  logic [TIME_BITS-1:0] ts;
  logic [1:0]           status;
  logic [4:0]           hout;
  logic [5:0]           nfired;
  logic                 in_tick;
  logic [IW-1:0]        idx;
  logic [TIME_BITS-1:0] cur_dl;
  logic [5:0]           cur_hd;
  logic [5:0]           alloc;
  logic                 out_full;
  logic                 out_load;
  dth_out_t             out_next;
  logic                 cancel_hit;

  // lowest free slot
  always_comb begin
    alloc = '0;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (!pending[i]) begin
        alloc = 6'(i);
      end
    end
  end

  function automatic logic less(input logic [TIME_BITS-1:0] da, input logic [5:0] ha,
                                input logic [TIME_BITS-1:0] db, input logic [5:0] hb);
    return (da != db) ? (da < db) : (ha < hb);
  endfunction

  logic [IW-1:0] parent, lchild, rchild;
  assign parent = (idx - IW'(1)) >> 1;
  assign lchild = {idx[IW-2:0], 1'b0} + IW'(1);
  assign rchild = lchild + IW'(1);

  logic                 l_ok, r_ok, pick_l, pick_r, take_l;
  logic [TIME_BITS-1:0] best_dl;
  logic [5:0]           best_hd;
  assign l_ok    = lchild < IW'(size);
  assign r_ok    = rchild < IW'(size);
  assign pick_l  = l_ok && less(rdl_a, rhd_a, cur_dl, cur_hd);
  assign best_dl = pick_l ? rdl_a : cur_dl;
  assign best_hd = pick_l ? rhd_a : cur_hd;
  assign pick_r  = r_ok && less(rdl_b, rhd_b, best_dl, best_hd);
  assign take_l  = pick_l && !pick_r;

  logic head_cancel, head_fire, head_pop, head_hold;
  assign head_cancel = (rhd_a < 6'(CAPACITY)) && cancelled[rhd_a[AW-1:0]];
  // a due live head fires only while the per-tick cap allows it
  assign head_fire   = in_tick && (ts >= rdl_a) && !head_cancel &&
                       (nfired < 6'(MAX_FIRED));
  assign head_pop    = head_cancel || head_fire;
  assign head_hold   = head_fire && out_full;

  assign cancel_hit = ({1'b0, in_req.task_handle} < 6'(CAPACITY)) &&
                      pending[AW'(in_req.task_handle)];

  assign out_full = out_valid && out_stall;
  assign in_stall = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    we      = 1'b0;
    waddr   = idx[AW-1:0];
    wdl     = cur_dl;
    whd     = cur_hd;
    raddr_a = '0;
    raddr_b = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = (in_req.kind == KIND_SCHED) ? S_SCHED : S_HEAD_RD;
        end
      end
      S_SCHED: begin
        state_next = (size < CW'(CAPACITY)) ? S_UP_RD : S_HEAD_RD;
      end
      S_UP_RD: begin
        raddr_a = parent[AW-1:0];
        if (idx == '0) begin
          we = 1'b1;
          state_next = S_HEAD_RD;
        end else begin
          state_next = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        we = 1'b1;
        if (less(cur_dl, cur_hd, rdl_a, rhd_a)) begin
          // move parent down, keep carrying the new entry
          wdl = rdl_a;
          whd = rhd_a;
          state_next = S_UP_RD;
        end else begin
          state_next = S_HEAD_RD;
        end
      end
      S_HEAD_RD: begin
        state_next = (size == '0) ? S_EMIT : S_HEAD_CHK;
      end
      S_HEAD_CHK: begin
        if (!head_hold) begin
          state_next = head_pop ? S_POP_MOVE : S_EMIT;
        end
      end
      S_POP_MOVE: begin
        raddr_a = AW'(size);
        state_next = (size == '0) ? S_HEAD_RD : S_POP_LD;
      end
      S_POP_LD: begin
        raddr_a = lchild[AW-1:0];
        raddr_b = rchild[AW-1:0];
        state_next = S_DN_CMP;
      end
      S_DN_RD: begin
        raddr_a = lchild[AW-1:0];
        raddr_b = rchild[AW-1:0];
        state_next = S_DN_CMP;
      end
      S_DN_CMP: begin
        we = 1'b1;
        if (pick_r) begin
          wdl = rdl_b;
          whd = rhd_b;
          state_next = S_DN_RD;
        end else if (take_l) begin
          wdl = rdl_a;
          whd = rhd_a;
          state_next = S_DN_RD;
        end else begin
          state_next = S_HEAD_RD;
        end
      end
      S_EMIT: begin
        if (!out_full) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    out_load = 1'b0;
    out_next = '0;
    if (state == S_HEAD_CHK && head_fire && !out_full) begin
      out_load            = 1'b1;
      out_next.out_handle = rhd_a[4:0];
      out_next.fired      = 1'b1;
    end else if (state == S_EMIT && !out_full) begin
      out_load               = 1'b1;
      out_next.out_handle    = hout;
      out_next.status        = status;
      out_next.next_deadline = (size == '0) ? '0 : 48'(cur_dl);
      out_next.task_count    = 6'(size);
      out_next.last          = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending   <= '0;
      cancelled <= '0;
      size      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
        out_req   <= out_next;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            ts      <= TIME_BITS'(in_req.timestamp);
            status  <= (in_req.kind == KIND_CANCEL && !cancel_hit) ? ST_NOT_PEND : ST_OK;
            hout    <= '0;
            nfired  <= '0;
            in_tick <= (in_req.kind == KIND_TICK);
            if (in_req.kind == KIND_CANCEL && cancel_hit) begin
              cancelled[AW'(in_req.task_handle)] <= 1'b1;
            end
          end
        end
        S_SCHED: begin
          if (size < CW'(CAPACITY)) begin
            pending[alloc[AW-1:0]]   <= 1'b1;
            cancelled[alloc[AW-1:0]] <= 1'b0;
            hout   <= alloc[4:0];
            idx    <= IW'(size);
            cur_dl <= ts;
            cur_hd <= alloc;
            size   <= size + CW'(1);
          end else begin
            status <= ST_FULL;
          end
        end
        S_UP_CMP: begin
          if (less(cur_dl, cur_hd, rdl_a, rhd_a)) idx <= parent;
        end
        S_HEAD_CHK: begin
          if (head_pop && !head_hold) begin
            if (rhd_a < 6'(CAPACITY)) begin
              pending[rhd_a[AW-1:0]]   <= 1'b0;
              cancelled[rhd_a[AW-1:0]] <= 1'b0;
            end
            if (head_fire) nfired <= nfired + 6'd1;
            size <= size - CW'(1);
            idx  <= '0;
          end else if (!head_pop) begin
            cur_dl <= rdl_a;
          end
        end
        S_POP_LD: begin
          // last entry becomes the carried entry for sift down
          cur_dl <= rdl_a;
          cur_hd <= rhd_a;
        end
        S_DN_CMP: begin
          if (pick_r) idx <= rchild;
          else if (take_l) idx <= lchild;
        end
        default: ;
      endcase
    end
  end

endmodule

@@ rtl/deadline_timer_heap.sv @@
// top level of the deadline timer heap
//  channel | dir | payload            | handshake
//  in      | in  | dth_in_t  in_data  | in_valid / in_stall
//  out     | out | dth_out_t out_data | out_valid / out_stall
// after an accepted request in_stall stays high until the summary is out: cancel, idle tick or
// unused kind pass head read, head check and emit; schedule adds the sift up in heap memory
// each task popped from the head adds a sift down of the last entry through the heap memory
// reset clears the handle bitmaps and the count; heap memory needs no clearing
// out_stall holds emit and a firing head check while a result waits in the output register
module deadline_timer_heap #(
  parameter int CAPACITY  = dth_pkg::CAPACITY_DEF,
  parameter int TIME_BITS = dth_pkg::TIME_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  dth_pkg::dth_in_t  in_data,
  input  logic              in_valid,
  output logic              in_stall,
  output dth_pkg::dth_out_t out_data,
  output logic              out_valid,
  input  logic              out_stall
);
  import dth_pkg::*;

  localparam int AW = $clog2(CAPACITY);

  logic                 we;
  logic [AW-1:0]        waddr, raddr_a, raddr_b;
  logic [TIME_BITS-1:0] wdl, rdl_a, rdl_b;
  logic [5:0]           whd, rhd_a, rhd_b;

  dth_heap_mem #(.CAPACITY(CAPACITY), .TIME_BITS(TIME_BITS), .AW(AW)) u_mem (
    .clk, .we, .waddr, .wdl, .whd, .raddr_a, .raddr_b, .rdl_a, .rhd_a, .rdl_b, .rhd_b
  );

  dth_ctrl #(.CAPACITY(CAPACITY), .TIME_BITS(TIME_BITS), .AW(AW)) u_ctrl (
    .clk, .rst, .in_req(in_data), .in_valid, .in_stall, .out_req(out_data), .out_valid,
    .out_stall, .we, .waddr, .wdl, .whd, .raddr_a, .raddr_b, .rdl_a, .rhd_a, .rdl_b, .rhd_b
  );

endmodule

@@ rtl/dth_checker.sv @@
// port-level checks for the deadline timer heap
module dth_checker (
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_stall,
  input dth_pkg::dth_out_t out_data,
  input logic              out_valid,
  input logic              out_stall
);
  import dth_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data)) else $error("output not held");
  a_fired_not_last: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_data.fired && out_data.last)) else $error("fired and last");
  a_fired_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.fired |-> out_data.status == ST_OK &&
    out_data.task_count == '0 && out_data.next_deadline == '0) else $error("fired fields");
  a_empty: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.last && out_data.task_count == '0 |->
    out_data.next_deadline == '0) else $error("empty heap deadline");
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall) else $error("not busy after request");

endmodule

bind deadline_timer_heap dth_checker u_chk (.*);
